// ----- hw/rtl/ecd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECC error address decoder package
// Shared types, register map and constants of the error address decoder.
// ----------------------------------------------------------------------------
package ecd_pkg;

	localparam int AddrW = 39;
	localparam int SynW = 16;
	localparam int PaddrW = 6;
	localparam int PdataW = 64;

	// 4 GiB boundary, at address width
	localparam logic [AddrW-1:0] FourGib = 39'h01_0000_0000;

	typedef enum logic [1:0] {
		ST_DECODED  = 2'd0,
		ST_NO_ERROR = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	// register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_LOW_DRAM_TOP  = 3'd0,
		REG_MEMORY_TOP    = 3'd1,
		REG_CHAN_HASH     = 3'd2,
		REG_SUBCHAN_HASH  = 3'd3,
		REG_CHAN_LAYOUT   = 3'd4,
		REG_DIMM_LAYOUT0  = 3'd5,
		REG_DIMM_LAYOUT1  = 3'd6,
		REG_DIMM_LARGE    = 3'd7
	} reg_idx_t;

	// front end result handed to the decode levels
	typedef struct packed {
		logic             valid;
		status_t          status;
		logic             unc;
		logic [SynW-1:0]  syn;
		logic [AddrW-1:0] sys;
		logic [AddrW-1:0] addr;
	} front_t;

endpackage

// ----- hw/rtl/ecd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECC decoder front end
// Two stages: unpack the log word, then remap around the low-memory hole
// and check the result against the memory top.
// ----------------------------------------------------------------------------
module ecd_front import ecd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [63:0]      log_word,
	input  logic [31:0]      low_dram_top,
	input  logic [AddrW-1:0] memory_top,
	output front_t           front_s2
);

	logic             valid_s1;
	logic             flagged_s1;
	logic             unc_s1;
	logic [SynW-1:0]  syn_s1;
	logic [AddrW-1:0] sys_s1;
	logic [AddrW+1:0] sum_s1;

	logic [31:0]      tolud;
	logic [AddrW-1:0] tom;
	logic [AddrW-1:0] sys_w;
	logic [AddrW+1:0] remap;
	logic             out_range;

	assign tolud = {low_dram_top[31:20], 20'd0};
	assign tom   = {memory_top[AddrW-1:20], 20'd0};
	assign sys_w = {log_word[38:5], 5'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		flagged_s1 <= log_word[63] | log_word[62];
		unc_s1     <= log_word[63];
		syn_s1     <= log_word[61:46];
		sys_s1     <= sys_w;
		sum_s1     <= {2'b00, sys_w} + {{(AddrW-30){1'b0}}, tolud};
	end

	// remap is signed: a negative value stands for a wrapped, huge address
	always_comb begin
		priority if (sys_s1 < {{(AddrW-32){1'b0}}, tolud}) begin
			remap = {2'b00, sys_s1};
		end else if (tom <= FourGib) begin
			remap = sum_s1 - {2'b00, FourGib};
		end else if (sys_s1 < FourGib) begin
			remap = sum_s1 - {2'b00, tom};
		end else begin
			remap = {2'b00, sys_s1};
		end
		out_range = remap[AddrW+1] || (remap[AddrW:0] >= {1'b0, tom});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s2 <= '0;
		end else begin
			front_s2.valid <= valid_s1;
			if (!flagged_s1) begin
				front_s2.status <= ST_NO_ERROR;
				front_s2.unc    <= 1'b0;
				front_s2.syn    <= '0;
				front_s2.sys    <= '0;
				front_s2.addr   <= '0;
			end else begin
				front_s2.status <= out_range ? ST_RANGE : ST_DECODED;
				front_s2.unc    <= unc_s1;
				front_s2.syn    <= syn_s1;
				front_s2.sys    <= sys_s1;
				front_s2.addr   <= out_range ? '0 : remap[AddrW-1:0];
			end
		end
	end

endmodule

// ----- hw/rtl/ecd_level.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECC decoder level
// One decode level: large-region rule, hashed interleave or bit-6
// interleave; gives the selected index and the address inside it.
// ----------------------------------------------------------------------------
module ecd_level import ecd_pkg::*; (
	input  logic [AddrW-1:0] addr,
	input  logic [31:0]      hash,
	input  logic [7:0]       small_units,
	input  logic             large_sel,
	output logic             sel,
	output logic [AddrW-1:0] sub
);

	logic [AddrW-1:0] s_size;
	logic [AddrW-1:0] two_s;
	logic [5:0]       bitpos;
	logic             parity;
	logic [AddrW-1:0] dropped;

	assign s_size = {2'b00, small_units, 29'd0};
	assign two_s  = {1'b0, small_units, 30'd0};
	assign bitpos = hash[28] ? (6'd6 + {3'd0, hash[26:24]}) : 6'd6;
	assign parity = hash[28] & (^(addr[19:6] & hash[19:6]));

	// remove the interleave bit, shift the upper part down
	always_comb begin
		dropped = '0;
		for (int i = 0; i < AddrW - 1; i++) begin
			dropped[i] = (i >= int'(bitpos)) ? addr[i+1] : addr[i];
		end
	end

	always_comb begin
		if (addr > two_s) begin
			sel = large_sel;
			sub = addr - s_size;
		end else begin
			sel = parity ^ addr[bitpos];
			sub = dropped;
		end
	end

endmodule

// ----- hw/rtl/ecc_error_address_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECC error address decoder
// Decodes an in-band ECC error log word into system, channel and
// sub-channel addresses.
// ----------------------------------------------------------------------------
// Takes one log word per clock: busy is always low, so a start is accepted
// in every cycle. Each transfer comes back on the result ports once it has
// passed all four register stages, marked by done for one cycle; the receiver
// cannot stall it, so sample it then. The four register stages are unpack, hole
// remap and range check, channel level, sub-channel level. Configuration goes
// through the APB port (64-bit data, register i at byte address 8*i) and is
// meant to be written only while no transfer is in flight.
// ----------------------------------------------------------------------------
module ecc_error_address_decoder import ecd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       log_word,
	output logic              done,
	output logic [1:0]        status,
	output logic              uncorrected,
	output logic [SynW-1:0]   syndrome,
	output logic [AddrW-1:0]  sys_address,
	output logic              channel,
	output logic [AddrW-1:0]  channel_address,
	output logic              subchannel,
	output logic [AddrW-1:0]  subchannel_address,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [PaddrW-1:0] paddr,
	input  logic [PdataW-1:0] pwdata,
	output logic [PdataW-1:0] prdata,
	output logic              pready
);

	// configuration registers
	logic [31:0]      low_dram_top_q;
	logic [AddrW-1:0] memory_top_q;
	logic [31:0]      chan_hash_q;
	logic [31:0]      subchan_hash_q;
	logic [31:0]      chan_layout_q;
	logic [31:0]      dimm_layout0_q;
	logic [31:0]      dimm_layout1_q;
	logic [1:0]       dimm_large_q;

	reg_idx_t reg_idx;
	logic     cfg_write;

	front_t front_s2;

	logic             ch_w;
	logic [AddrW-1:0] cha_w;
	logic             sc_w;
	logic [AddrW-1:0] sca_w;
	logic [6:0]       dimm_small;

	logic             valid_s3;
	status_t          status_s3;
	logic             unc_s3;
	logic [SynW-1:0]  syn_s3;
	logic [AddrW-1:0] sys_s3;
	logic             ch_s3;
	logic [AddrW-1:0] cha_s3;

	logic             valid_s4;
	status_t          status_s4;
	logic             unc_s4;
	logic [SynW-1:0]  syn_s4;
	logic [AddrW-1:0] sys_s4;
	logic             ch_s4;
	logic [AddrW-1:0] cha_s4;
	logic             sc_s4;
	logic [AddrW-1:0] sca_s4;

	// the pipeline never holds off a start
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// ---------------------------------------------------------------- APB
	assign reg_idx   = reg_idx_t'(paddr[5:3]);
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_dram_top_q <= '0;
			memory_top_q   <= '0;
			chan_hash_q    <= '0;
			subchan_hash_q <= '0;
			chan_layout_q  <= '0;
			dimm_layout0_q <= '0;
			dimm_layout1_q <= '0;
			dimm_large_q   <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_LOW_DRAM_TOP: low_dram_top_q <= pwdata[31:0];
				REG_MEMORY_TOP:   memory_top_q   <= pwdata[AddrW-1:0];
				REG_CHAN_HASH:    chan_hash_q    <= pwdata[31:0];
				REG_SUBCHAN_HASH: subchan_hash_q <= pwdata[31:0];
				REG_CHAN_LAYOUT:  chan_layout_q  <= pwdata[31:0];
				REG_DIMM_LAYOUT0: dimm_layout0_q <= pwdata[31:0];
				REG_DIMM_LAYOUT1: dimm_layout1_q <= pwdata[31:0];
				REG_DIMM_LARGE:   dimm_large_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LOW_DRAM_TOP: prdata = {32'd0, low_dram_top_q};
			REG_MEMORY_TOP:   prdata = {{(PdataW-AddrW){1'b0}}, memory_top_q};
			REG_CHAN_HASH:    prdata = {32'd0, chan_hash_q};
			REG_SUBCHAN_HASH: prdata = {32'd0, subchan_hash_q};
			REG_CHAN_LAYOUT:  prdata = {32'd0, chan_layout_q};
			REG_DIMM_LAYOUT0: prdata = {32'd0, dimm_layout0_q};
			REG_DIMM_LAYOUT1: prdata = {32'd0, dimm_layout1_q};
			REG_DIMM_LARGE:   prdata = {62'd0, dimm_large_q};
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------- stages 1 and 2
	ecd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.log_word     (log_word),
		.low_dram_top (low_dram_top_q),
		.memory_top   (memory_top_q),
		.front_s2     (front_s2)
	);

	// ---------------------------------------------- stage 3: channel level
	ecd_level u_level_ch (
		.addr        (front_s2.addr),
		.hash        (chan_hash_q),
		.small_units (chan_layout_q[19:12]),
		.large_sel   (chan_layout_q[4]),
		.sel         (ch_w),
		.sub         (cha_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= front_s2.valid;
		end
	end

	// drop the level result unless the address decoded
	always_ff @(posedge clk) begin
		status_s3 <= front_s2.status;
		unc_s3    <= front_s2.unc;
		syn_s3    <= front_s2.syn;
		sys_s3    <= front_s2.sys;
		if (front_s2.status == ST_DECODED) begin
			ch_s3  <= ch_w;
			cha_s3 <= cha_w;
		end else begin
			ch_s3  <= 1'b0;
			cha_s3 <= '0;
		end
	end

	// ------------------------------------------ stage 4: sub-channel level
	assign dimm_small = ch_s3 ? dimm_layout1_q[22:16] : dimm_layout0_q[22:16];

	ecd_level u_level_sc (
		.addr        (cha_s3),
		.hash        (subchan_hash_q),
		.small_units ({1'b0, dimm_small}),
		.large_sel   (dimm_large_q[ch_s3]),
		.sel         (sc_w),
		.sub         (sca_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		status_s4 <= status_s3;
		unc_s4    <= unc_s3;
		syn_s4    <= syn_s3;
		sys_s4    <= sys_s3;
		ch_s4     <= ch_s3;
		cha_s4    <= cha_s3;
		if (status_s3 == ST_DECODED) begin
			sc_s4  <= sc_w;
			sca_s4 <= sca_w;
		end else begin
			sc_s4  <= 1'b0;
			sca_s4 <= '0;
		end
	end

	// ------------------------------------------------------------- result
	assign done               = valid_s4;
	assign status             = status_s4;
	assign uncorrected        = unc_s4;
	assign syndrome           = syn_s4;
	assign sys_address        = sys_s4;
	assign channel            = ch_s4;
	assign channel_address    = cha_s4;
	assign subchannel         = sc_s4;
	assign subchannel_address = sca_s4;

`ifndef NO_ASSERTIONS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("transfer not returned after four cycles");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result strobe without a matching start");

	a_no_error_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NO_ERROR) |->
			(!uncorrected && syndrome == '0 && sys_address == '0))
		else $error("no-error result carries payload");

	a_undecoded_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DECODED) |->
			(!channel && !subchannel && channel_address == '0
			&& subchannel_address == '0))
		else $error("undecoded result carries channel fields");
`endif

endmodule
